// ----- sv/tfdi_pkg.sv -----
// Shared types, constants and helper functions for the three-field deinterlacer column.
package tfdi_pkg;

  localparam int PIX_W    = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register index decoded from the byte address (one 32-bit word per register).
  localparam logic [0:0] REG_FIELD_PARITY = 1'b0;

  // Filter coefficients.
  localparam int K_HF0  = 5570;
  localparam int K_HF1  = 3801;
  localparam int K_HF2  = 1016;
  localparam int K_LF0  = 4 * 4309;
  localparam int K_LF1  = 4 * 213;
  localparam int K_SP0  = 5077;
  localparam int K_SP1  = 981;
  localparam int SH_TS  = 15;
  localparam int SH_SP  = 13;

  localparam int PROD_W = 26;
  localparam int VAL_W  = 16;

  typedef logic signed [11:0]         sw_t;
  typedef logic signed [PROD_W-1:0]   pw_t;
  typedef logic signed [VAL_W-1:0]    vw_t;

  typedef struct packed {
    logic [47:0] cur_even_taps;
    logic [39:0] cur_odd_taps;
    logic [47:0] prev_even_taps;
    logic [23:0] prev_odd_taps;
    logic [47:0] next_even_taps;
    logic [23:0] next_odd_taps;
    logic        last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper_pixel;
    logic [PIX_W-1:0] middle_pixel;
    logic [PIX_W-1:0] lower_pixel;
    logic             last_out;
  } out_item_t;

  function automatic sw_t abs_s(sw_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic sw_t max_s(sw_t a, sw_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic sw_t min_s(sw_t a, sw_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- sv/tfdi_interp.sv -----
// Builds one missing pixel: filter choice, motion and edge clamp, saturation.
module tfdi_interp import tfdi_pkg::*; (
  input  logic [8:0]       s0,
  input  logic [8:0]       sa,
  input  logic [8:0]       sb,
  input  logic [8:0]       fa,
  input  logic [8:0]       fb,
  input  logic [7:0]       td,
  input  logic [7:0]       c,
  input  logic [7:0]       e,
  input  logic [7:0]       oa,
  input  logic [7:0]       ob,
  input  logic [7:0]       pc,
  input  logic [7:0]       pe,
  input  logic [7:0]       nc,
  input  logic [7:0]       ne,
  output logic [PIX_W-1:0] pix
);

  sw_t        c_s, e_s, d_s, b_s, f_s, dc, de, t1, t2, spmax, spmin, diff, td_s;
  logic [9:0] sum_ab, sum_f;
  logic [8:0] sum_ce, sum_o;
  pw_t        hv, sv;
  vw_t        v_sel, hi_lim, lo_lim, v_clamp;
  logic       use_ts;

  always_comb begin
    c_s  = sw_t'({4'b0, c});
    e_s  = sw_t'({4'b0, e});
    td_s = sw_t'({4'b0, td});
    d_s  = sw_t'({4'b0, s0[8:1]});
    b_s  = sw_t'({4'b0, sa[8:1]}) - c_s;
    f_s  = sw_t'({4'b0, sb[8:1]}) - e_s;
    dc   = d_s - c_s;
    de   = d_s - e_s;

    t1 = (abs_s(sw_t'({4'b0, pc}) - c_s) + abs_s(sw_t'({4'b0, pe}) - e_s)) >>> 1;
    t2 = (abs_s(sw_t'({4'b0, nc}) - c_s) + abs_s(sw_t'({4'b0, ne}) - e_s)) >>> 1;

    spmax = min_s(min_s(-de, -dc), max_s(-b_s, -f_s));
    spmin = min_s(min_s(de, dc), max_s(b_s, f_s));
    diff  = max_s(max_s(td_s >>> 1, max_s(t1, t2)), max_s(spmin, spmax));

    sum_ab = {1'b0, sa} + {1'b0, sb};
    sum_f  = {1'b0, fa} + {1'b0, fb};
    sum_ce = {1'b0, c} + {1'b0, e};
    sum_o  = {1'b0, oa} + {1'b0, ob};

    hv = pw_t'(K_HF0) * pw_t'({17'd0, s0})
       - pw_t'(K_HF1) * pw_t'({16'd0, sum_ab})
       + pw_t'(K_HF2) * pw_t'({16'd0, sum_f})
       + pw_t'(K_LF0) * pw_t'({17'd0, sum_ce})
       - pw_t'(K_LF1) * pw_t'({17'd0, sum_o});
    sv = pw_t'(K_SP0) * pw_t'({17'd0, sum_ce})
       - pw_t'(K_SP1) * pw_t'({17'd0, sum_o});

    // Temporal-plus-spatial filter only where the field's vertical step
    // exceeds the temporal difference.
    use_ts = abs_s(c_s - e_s) > td_s;
    if (use_ts) begin
      v_sel = vw_t'($signed(hv[PROD_W-1:SH_TS]));
    end else begin
      v_sel = vw_t'($signed(sv[PROD_W-1:SH_SP]));
    end

    hi_lim = vw_t'(d_s) + vw_t'(diff);
    lo_lim = vw_t'(d_s) - vw_t'(diff);
    if (v_sel > hi_lim) begin
      v_clamp = hi_lim;
    end else if (v_sel < lo_lim) begin
      v_clamp = lo_lim;
    end else begin
      v_clamp = v_sel;
    end

    if (v_clamp < 0) begin
      pix = '0;
    end else if (v_clamp > vw_t'(255)) begin
      pix = '1;
    end else begin
      pix = v_clamp[PIX_W-1:0];
    end
  end

endmodule

// ----- sv/tfdi_column.sv -----
// Unpacks one column of taps, picks the temporal partner frame and forms the three outputs.
module tfdi_column import tfdi_pkg::*; (
  input  in_item_t  item,
  input  logic      field_parity,
  output out_item_t res
);

  logic [47:0] oe;
  logic [7:0]  ce_t [6];
  logic [7:0]  oe_t [6];
  logic [8:0]  s    [6];
  logic [7:0]  co_t [5];
  logic [7:0]  po_t [3];
  logic [7:0]  no_t [3];
  logic [7:0]  td0, td2;
  logic [7:0]  upper, lower;

  always_comb begin
    oe = field_parity ? item.prev_even_taps : item.next_even_taps;
    for (int k = 0; k < 6; k++) begin
      ce_t[k] = item.cur_even_taps[8*k +: 8];
      oe_t[k] = oe[8*k +: 8];
      s[k]    = {1'b0, ce_t[k]} + {1'b0, oe_t[k]};
    end
    for (int k = 0; k < 5; k++) begin
      co_t[k] = item.cur_odd_taps[8*k +: 8];
    end
    for (int k = 0; k < 3; k++) begin
      po_t[k] = item.prev_odd_taps[8*k +: 8];
      no_t[k] = item.next_odd_taps[8*k +: 8];
    end
    td0 = (ce_t[2] > oe_t[2]) ? ce_t[2] - oe_t[2] : oe_t[2] - ce_t[2];
    td2 = (ce_t[3] > oe_t[3]) ? ce_t[3] - oe_t[3] : oe_t[3] - ce_t[3];
  end

  tfdi_interp u_upper (
    .s0 (s[2]),    .sa (s[1]),    .sb (s[3]),    .fa (s[0]),    .fb (s[4]),
    .td (td0),     .c  (co_t[1]), .e  (co_t[2]), .oa (co_t[0]), .ob (co_t[3]),
    .pc (po_t[0]), .pe (po_t[1]), .nc (no_t[0]), .ne (no_t[1]), .pix (upper)
  );

  tfdi_interp u_lower (
    .s0 (s[3]),    .sa (s[2]),    .sb (s[4]),    .fa (s[1]),    .fb (s[5]),
    .td (td2),     .c  (co_t[2]), .e  (co_t[3]), .oa (co_t[1]), .ob (co_t[4]),
    .pc (po_t[1]), .pe (po_t[2]), .nc (no_t[1]), .ne (no_t[2]), .pix (lower)
  );

  always_comb begin
    res.upper_pixel  = upper;
    res.middle_pixel = co_t[2];
    res.lower_pixel  = lower;
    res.last_out     = item.last_in_row;
  end

endmodule

// ----- sv/tfdi_cfg.sv -----
// APB register file holding the field parity setting.
module tfdi_cfg import tfdi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic              field_parity
);

  logic       field_parity_r, field_parity_nxt;
  logic       wr_en;
  logic [0:0] reg_idx;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    field_parity_nxt = field_parity_r;
    if (wr_en && (reg_idx == REG_FIELD_PARITY)) begin
      field_parity_nxt = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FIELD_PARITY) begin
      prdata = {{(APB_DW-1){1'b0}}, field_parity_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_parity_r <= 1'b0;
    end else begin
      field_parity_r <= field_parity_nxt;
    end
  end

  assign field_parity = field_parity_r;

endmodule

// ----- sv/three_field_deinterlace_column.sv -----
// Three-field deinterlacer for one pixel column: each accepted item gives exactly one
// result holding two interpolated pixels and a copy of the current row +1 pixel. The
// block takes one item per clock when the output side keeps up. Each item is held in the input
// register while the logic behind it does all the filtering, then moves into the result
// register, from which its result is presented. The input register lets one more item in
// while a finished result waits on out_stall.
// field_parity is written over APB at byte address 0 and should only change while idle.
module three_field_deinterlace_column import tfdi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r, s1_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t res;
  logic      field_parity;
  logic      s1_adv, in_acc;

  tfdi_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .field_parity (field_parity)
  );

  tfdi_column u_column (
    .item         (s1_item_r),
    .field_parity (field_parity),
    .res          (res)
  );

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = in_item;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_item_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // The input side only pushes back when the input register is holding an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with an empty input register");

  // An item that cannot move on stays in the input register.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost an item while blocked");

  // A moving item lands in the result register with its pass-through fields.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> (out_valid_r
      && out_item_r.middle_pixel == $past(s1_item_r.cur_odd_taps[23:16])
      && out_item_r.last_out == $past(s1_item_r.last_in_row)))
    else $error("result register does not match the item that moved");
`endif

endmodule

// ----- bench/deinterlace_column_checker.sv -----
// Checker for the deinterlacer column: predicts each result, compares it and tracks the parity register.
module deinterlace_column_checker import tfdi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  output int                pending,
  output int                mismatch_total
);

  // Temporal-plus-spatial filter weights, result scaled by 2^15.
  localparam int TS_MID   = 5570;
  localparam int TS_NEAR  = 3801;
  localparam int TS_FAR   = 1016;
  localparam int TS_CUR   = 4 * 4309;
  localparam int TS_OUTER = 4 * 213;
  localparam int TS_SHIFT = 15;
  // Spatial-only filter weights, result scaled by 2^13.
  localparam int SP_CUR   = 5077;
  localparam int SP_OUTER = 981;
  localparam int SP_SHIFT = 13;

  out_item_t expected_cols[$];
  logic      parity_sel = 1'b0;
  int        errors = 0;

  function automatic int abs_i(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int max_i(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int min_i(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int row_px(logic [47:0] taps, int k);
    return int'(taps[8*k +: 8]);
  endfunction

  // One missing pixel. s0 is the temporal sum at the missing row, sa/sb the sums two rows
  // away, fa/fb four rows away; c/e are the current rows adjacent, oa/ob three rows away.
  function automatic logic [7:0] missing_pixel(int s0, int td, int sa, int sb, int fa, int fb,
                                               int c, int e, int oa, int ob,
                                               int pc, int pe, int nc, int ne);
    int avg, mot_p, mot_n, bound, up, dn, dc, de, sp_hi, sp_lo, v;
    avg   = s0 >>> 1;
    mot_p = (abs_i(pc - c) + abs_i(pe - e)) >>> 1;
    mot_n = (abs_i(nc - c) + abs_i(ne - e)) >>> 1;
    bound = max_i(td >>> 1, max_i(mot_p, mot_n));
    up    = (sa >>> 1) - c;
    dn    = (sb >>> 1) - e;
    dc    = avg - c;
    de    = avg - e;
    sp_hi = min_i(min_i(-de, -dc), max_i(-up, -dn));
    sp_lo = min_i(min_i(de, dc), max_i(up, dn));
    bound = max_i(bound, max_i(sp_lo, sp_hi));
    if (abs_i(c - e) > td) begin
      v = (TS_MID * s0 - TS_NEAR * (sa + sb) + TS_FAR * (fa + fb)
           + TS_CUR * (c + e) - TS_OUTER * (oa + ob)) >>> TS_SHIFT;
    end else begin
      v = (SP_CUR * (c + e) - SP_OUTER * (oa + ob)) >>> SP_SHIFT;
    end
    if (v > avg + bound) v = avg + bound;
    else if (v < avg - bound) v = avg - bound;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic out_item_t predict_column(in_item_t col, logic use_prev);
    out_item_t   res;
    logic [47:0] pair_even;
    logic [47:0] cur_odd, prev_odd, next_odd;
    int          sum [6];
    int          td_up, td_dn, m3, m1, p1, p3, p5;
    pair_even = use_prev ? col.prev_even_taps : col.next_even_taps;
    cur_odd   = 48'(col.cur_odd_taps);
    prev_odd  = 48'(col.prev_odd_taps);
    next_odd  = 48'(col.next_odd_taps);
    for (int k = 0; k < 6; k++) sum[k] = row_px(col.cur_even_taps, k) + row_px(pair_even, k);
    td_up = abs_i(row_px(col.cur_even_taps, 2) - row_px(pair_even, 2));
    td_dn = abs_i(row_px(col.cur_even_taps, 3) - row_px(pair_even, 3));
    m3 = row_px(cur_odd, 0);
    m1 = row_px(cur_odd, 1);
    p1 = row_px(cur_odd, 2);
    p3 = row_px(cur_odd, 3);
    p5 = row_px(cur_odd, 4);
    res.upper_pixel = missing_pixel(sum[2], td_up, sum[1], sum[3], sum[0], sum[4],
                                    m1, p1, m3, p3,
                                    row_px(prev_odd, 0), row_px(prev_odd, 1),
                                    row_px(next_odd, 0), row_px(next_odd, 1));
    res.middle_pixel = p1[7:0];
    res.lower_pixel = missing_pixel(sum[3], td_dn, sum[2], sum[4], sum[1], sum[5],
                                    p1, p3, m1, p5,
                                    row_px(prev_odd, 1), row_px(prev_odd, 2),
                                    row_px(next_odd, 1), row_px(next_odd, 2));
    res.last_out = col.last_in_row;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      expected_cols.delete();
      parity_sel = 1'b0;
    end else begin
      // A result always leaves after its item was accepted, so check before queuing new ones.
      if (out_valid && !out_stall) begin
        if (expected_cols.size() == 0) begin
          $error("result item arrived with no column pending");
          errors++;
        end else begin
          want = expected_cols.pop_front();
          if (out_item.upper_pixel !== want.upper_pixel) begin
            $error("upper_pixel: expected %0d, actual %0d", want.upper_pixel,
                   out_item.upper_pixel);
            errors++;
          end
          if (out_item.middle_pixel !== want.middle_pixel) begin
            $error("middle_pixel: expected %0d, actual %0d", want.middle_pixel,
                   out_item.middle_pixel);
            errors++;
          end
          if (out_item.lower_pixel !== want.lower_pixel) begin
            $error("lower_pixel: expected %0d, actual %0d", want.lower_pixel,
                   out_item.lower_pixel);
            errors++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out: expected %0d, actual %0d", want.last_out, out_item.last_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_cols.push_back(predict_column(in_item, parity_sel));
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_FIELD_PARITY) begin
        if (pwrite) begin
          parity_sel = pwdata[0];
        end else if (prdata[0] !== parity_sel) begin
          $error("field_parity: expected %0d, actual %0d", parity_sel, prdata[0]);
          errors++;
        end
      end
    end
    pending        <= expected_cols.size();
    mismatch_total <= errors;
  end

endmodule

// ----- bench/tb_three_field_deinterlace_column.sv -----
// Testbench top for the deinterlacer column: clock, reset, stimulus, receiver stalls and verdict.
module tb_three_field_deinterlace_column import tfdi_pkg::*; ();

  localparam logic [APB_AW-1:0] PARITY_ADDR = {REG_FIELD_PARITY, 2'b00};
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int LONG_HOLD     = 60;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                pending;
  int                mismatch_total;

  logic              hold_req = 1'b0;
  logic              hold_served = 1'b0;
  int                hold_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;
  int                mode_left = 0;
  int                tick = 0;

  three_field_deinterlace_column dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  deinterlace_column_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .pending, .mismatch_total
  );

  always #10 clk = ~clk;

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: a random stall pattern whose mode is redrawn whenever its run ends, plus one long
  // hold-off on request so that the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (mode_left == 0) begin
      hold_left  <= 0;
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(10, 80);
      out_stall  <= 1'b0;
    end else begin
      hold_left <= 0;
      mode_left <= mode_left - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          tick      <= (tick == 2) ? 0 : tick + 1;
          out_stall <= (tick == 2);
        end
      endcase
    end
  end

  function automatic logic [7:0] nudge(int v, int spread);
    int r;
    r = v + $urandom_range(0, 2 * spread) - spread;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  // Smooth columns reach the spatial filter and the clamps; extreme ones hit saturation.
  function automatic logic [7:0] pick_pixel(int style, int base);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return nudge(base, 6);
      2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return nudge(base, 40);
    endcase
  endfunction

  function automatic in_item_t random_column();
    in_item_t col;
    int       style, base, motion;
    style  = $urandom_range(0, 3);
    base   = $urandom_range(0, 255);
    motion = $urandom_range(0, 2);
    for (int k = 0; k < 6; k++) col.cur_even_taps[8*k +: 8] = pick_pixel(style, base);
    for (int k = 0; k < 5; k++) col.cur_odd_taps[8*k +: 8] = pick_pixel(style, base);
    for (int k = 0; k < 6; k++) begin
      case (motion)
        0: begin
          col.prev_even_taps[8*k +: 8] = col.cur_even_taps[8*k +: 8];
          col.next_even_taps[8*k +: 8] = col.cur_even_taps[8*k +: 8];
        end
        1: begin
          col.prev_even_taps[8*k +: 8] = nudge(int'(col.cur_even_taps[8*k +: 8]), 10);
          col.next_even_taps[8*k +: 8] = nudge(int'(col.cur_even_taps[8*k +: 8]), 10);
        end
        default: begin
          col.prev_even_taps[8*k +: 8] = pick_pixel(style, base);
          col.next_even_taps[8*k +: 8] = pick_pixel(style, base);
        end
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      if (motion == 0) begin
        col.prev_odd_taps[8*k +: 8] = col.cur_odd_taps[8*(k+1) +: 8];
        col.next_odd_taps[8*k +: 8] = col.cur_odd_taps[8*(k+1) +: 8];
      end else begin
        col.prev_odd_taps[8*k +: 8] = pick_pixel(style, base);
        col.next_odd_taps[8*k +: 8] = pick_pixel(style, base);
      end
    end
    col.last_in_row = ($urandom_range(0, 15) == 0);
    return col;
  endfunction

  task automatic send_column(input in_item_t col);
    in_item  <= col;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only bit 0 belongs to the register.
  task automatic set_parity(input logic p);
    logic [APB_DW-1:0] data;
    data    = $urandom;
    data[0] = p;
    drain();
    reg_access(1'b1, PARITY_ADDR, data);
    reg_access(1'b0, PARITY_ADDR, '0);
  endtask

  initial begin
    in_item_t corner [12];
    int       burst_left;
    int       gap;

    // Field order: cur even, cur odd, prev even, prev odd, next even, next odd, last.
    corner[0]  = in_item_t'{48'h0, 40'h0, 48'h0, 24'h0, 48'h0, 24'h0, 1'b0};
    corner[1]  = in_item_t'{{6{8'hFF}}, {5{8'hFF}}, {6{8'hFF}}, {3{8'hFF}},
                            {6{8'hFF}}, {3{8'hFF}}, 1'b1};
    // A still, flat picture leaves no motion bound: the result is the temporal average.
    corner[2]  = in_item_t'{{6{8'h80}}, {5{8'h80}}, {6{8'h80}}, {3{8'h80}},
                            {6{8'h80}}, {3{8'h80}}, 1'b0};
    // Large vertical gap with no temporal change selects the temporal-plus-spatial filter.
    corner[3]  = in_item_t'{{6{8'h80}}, 40'hFF00FF00FF, {6{8'h80}}, 24'h00FF00,
                            {6{8'h80}}, 24'h00FF00, 1'b0};
    // Temporal change as large as the vertical gap selects the spatial filter.
    corner[4]  = in_item_t'{{6{8'h00}}, 40'h00FF00FF00, {6{8'hFF}}, 24'hFF00FF,
                            {6{8'hFF}}, 24'hFF00FF, 1'b1};
    corner[5]  = in_item_t'{{6{8'h00}}, 40'h00FF0000FF, {6{8'hFF}}, 24'h000000,
                            {6{8'h00}}, 24'hFFFFFF, 1'b0};
    corner[6]  = in_item_t'{{6{8'hFF}}, 40'hFF00FFFF00, {6{8'h00}}, 24'hFFFFFF,
                            {6{8'hFF}}, 24'h000000, 1'b0};
    corner[7]  = in_item_t'{{6{8'h55}}, {5{8'h55}}, {6{8'h55}}, {3{8'h55}},
                            {6{8'h55}}, {3{8'h55}}, 1'b1};
    corner[8]  = in_item_t'{{6{8'hAA}}, {5{8'hAA}}, {6{8'hAA}}, {3{8'hAA}},
                            {6{8'hAA}}, {3{8'hAA}}, 1'b0};
    // Previous and next frames disagree, so the result follows the parity setting.
    corner[9]  = in_item_t'{48'h605040302010, 40'h5848382818, 48'hFFEEDDCCBBAA, 24'h000000,
                            48'h605040302010, 24'hFFFFFF, 1'b0};
    corner[10] = in_item_t'{48'h00FF00FF00FF, 40'h00FF00FF00, 48'hFF00FF00FF00, 24'h00FF00,
                            48'h00FF00FF00FF, 24'hFF00FF, 1'b1};
    corner[11] = in_item_t'{{6{8'h40}}, {5{8'h40}}, {6{8'h40}}, 24'hFFFFFF,
                            {6{8'h40}}, 24'h000000, 1'b0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    reg_access(1'b0, PARITY_ADDR, '0);

    foreach (corner[i]) send_column(corner[i]);
    set_parity(1'b1);
    foreach (corner[i]) send_column(corner[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_parity((phase % 2 == 0) ? 1'b0 : 1'b1);
      burst_left = 0;
      if (phase == 1) begin
        // Keep offering items through the long hold-off so the block fills and stalls.
        hold_req   <= 1'b1;
        burst_left = 3 * LONG_HOLD;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          idle_cycles(gap);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 24);
        end
        send_column(random_column());
        burst_left--;
      end
    end

    drain();
    if (mismatch_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
